>>> hdl/slrl_pkg.sv
package slrl_pkg;

    localparam int RING_DEPTH_DEF = 64;

    localparam int TIME_W     = 32;
    localparam int WIN_W      = 31;
    localparam int MAXREQ_W   = 7;
    localparam int CNT_OUT_W  = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;

    localparam logic [MAXREQ_W-1:0] MAXREQ_RST = 7'd5;
    localparam logic [WIN_W-1:0]    WINDOW_RST = 31'd10000;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_REQUESTS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TICKS = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_CMP    = 3'b010,
        ST_DECIDE = 3'b100
    } t_state;

    // Write side of the stamp memory, as driven by the sequencer.
    typedef struct packed {
        logic              we;
        logic [TIME_W-1:0] wdata;
    } t_ram_wr;

endpackage

>>> hdl/slrl_if.sv
interface slrl_req_if;
    logic                        valid;
    logic                        ready;
    logic [slrl_pkg::TIME_W-1:0] arrival_time;

    modport source (output valid, output arrival_time, input ready);
    modport sink   (input valid, input arrival_time, output ready);
    modport mon    (input valid, input arrival_time, input ready);
endinterface

interface slrl_res_if;
    logic                           valid;
    logic                           ready;
    logic                           allowed;
    logic [slrl_pkg::CNT_OUT_W-1:0] in_window;

    modport source (output valid, output allowed, output in_window, input ready);
    modport sink   (input valid, input allowed, input in_window, output ready);
    modport mon    (input valid, input allowed, input in_window, input ready);
endinterface

>>> hdl/slrl_ram.sv
module slrl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> hdl/slrl_age_unit.sv
module slrl_age_unit (
    input  logic [slrl_pkg::TIME_W-1:0] i_now,
    input  logic [slrl_pkg::TIME_W-1:0] i_stamp,
    input  logic [slrl_pkg::WIN_W-1:0]  i_window,
    output logic                        o_expired
);

    logic [slrl_pkg::TIME_W-1:0] age;

    // The age wraps modulo the timestamp width, so a stamp from the future looks old.
    assign age       = i_now - i_stamp;
    assign o_expired = (age >= {1'b0, i_window});

endmodule

>>> hdl/sliding_log_rate_limiter.sv
// Channel     | Dir | Beat carries
// ------------+-----+----------------------------------------------
// i_req       | in  | arrival_time (32 bits)
// o_res       | out | allowed (1 bit), in_window (7 bits)
// i_cfg_*     | in  | write of max_requests (0) or window_ticks (1)
//
// A request passes through an accept state, one compare per stamp examined
// against the shared age unit (the memory read port delivers one stamp a cycle),
// and a decide state; the compares stop at the first stamp that has not expired
// or once every stamp has expired, and an empty ring skips the compare. Reset
// clears the ring pointers, count, state, result valid and configuration
// registers; the stamp memory is not cleared. A stalled result holds the decide
// state, while a new request is taken as soon as the result is registered.
module sliding_log_rate_limiter #(
    parameter int RING_DEPTH = slrl_pkg::RING_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    slrl_req_if.sink                        i_req,
    slrl_res_if.source                      o_res,
    input  logic                            i_cfg_we,
    input  logic [slrl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [slrl_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam int CMP_W = (CNT_W > slrl_pkg::MAXREQ_W) ? CNT_W : slrl_pkg::MAXREQ_W;

    slrl_pkg::t_state r_state, n_state;

    logic [slrl_pkg::TIME_W-1:0]   r_now, n_now;
    logic [PTR_W-1:0]              r_oldest, n_oldest;
    logic [PTR_W-1:0]              r_tail, n_tail;
    logic [CNT_W-1:0]              r_count, n_count;
    logic [slrl_pkg::MAXREQ_W-1:0] r_max_req;
    logic [slrl_pkg::WIN_W-1:0]    r_window;
    logic                          r_out_valid, n_out_valid;
    logic                          r_out_allowed, n_out_allowed;
    logic [slrl_pkg::CNT_OUT_W-1:0] r_out_in_win, n_out_in_win;

    slrl_pkg::t_ram_wr             ram_wr;
    logic [PTR_W-1:0]              ram_raddr;
    logic [slrl_pkg::TIME_W-1:0]   ram_rdata;
    logic                          expired;
    logic                          room;
    logic [CNT_W-1:0]              count_after;
    logic [CNT_W+slrl_pkg::CNT_OUT_W-1:0] count_wide;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] q;
        q = (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
        return q;
    endfunction

    slrl_ram #(
        .WIDTH (slrl_pkg::TIME_W),
        .DEPTH (RING_DEPTH),
        .AW    (PTR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_wr.we),
        .i_waddr (r_tail),
        .i_wdata (ram_wr.wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    slrl_age_unit u_age (
        .i_now     (r_now),
        .i_stamp   (ram_rdata),
        .i_window  (r_window),
        .o_expired (expired)
    );

    // The limit is min(max_requests, depth); the count never exceeds the depth.
    assign room = (CMP_W'(r_count) < CMP_W'(r_max_req)) &&
                  (r_count < CNT_W'(RING_DEPTH));
    assign count_after = room ? r_count + 1'b1 : r_count;
    assign count_wide  = {{slrl_pkg::CNT_OUT_W{1'b0}}, count_after};

    always_comb begin
        n_state       = r_state;
        n_now         = r_now;
        n_oldest      = r_oldest;
        n_tail        = r_tail;
        n_count       = r_count;
        n_out_valid   = r_out_valid;
        n_out_allowed = r_out_allowed;
        n_out_in_win  = r_out_in_win;
        ram_wr.we     = 1'b0;
        ram_wr.wdata  = r_now;
        ram_raddr     = r_oldest;

        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            slrl_pkg::ST_IDLE: begin
                if (i_req.valid) begin
                    n_now   = i_req.arrival_time;
                    n_state = (r_count == '0) ? slrl_pkg::ST_DECIDE : slrl_pkg::ST_CMP;
                end
            end
            slrl_pkg::ST_CMP: begin
                if (expired) begin
                    n_oldest  = ptr_inc(r_oldest);
                    n_count   = r_count - 1'b1;
                    ram_raddr = ptr_inc(r_oldest);
                    if (r_count == CNT_W'(1)) begin
                        n_state = slrl_pkg::ST_DECIDE;
                    end
                end else begin
                    n_state = slrl_pkg::ST_DECIDE;
                end
            end
            slrl_pkg::ST_DECIDE: begin
                if (!r_out_valid || o_res.ready) begin
                    if (room) begin
                        ram_wr.we = 1'b1;
                        n_tail    = ptr_inc(r_tail);
                    end
                    n_count       = count_after;
                    n_out_valid   = 1'b1;
                    n_out_allowed = room;
                    n_out_in_win  = count_wide[slrl_pkg::CNT_OUT_W-1:0];
                    n_state       = slrl_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = slrl_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= slrl_pkg::ST_IDLE;
            r_oldest    <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_max_req   <= slrl_pkg::MAXREQ_RST;
            r_window    <= slrl_pkg::WINDOW_RST;
        end else begin
            r_state     <= n_state;
            r_oldest    <= n_oldest;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    slrl_pkg::CFG_MAX_REQUESTS: r_max_req <= i_cfg_data[slrl_pkg::MAXREQ_W-1:0];
                    slrl_pkg::CFG_WINDOW_TICKS: r_window  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_now         <= n_now;
        r_out_allowed <= n_out_allowed;
        r_out_in_win  <= n_out_in_win;
    end

    assign i_req.ready     = (r_state == slrl_pkg::ST_IDLE);
    assign o_res.valid     = r_out_valid;
    assign o_res.allowed   = r_out_allowed;
    assign o_res.in_window = r_out_in_win;

endmodule

>>> hdl/slrl_checker.sv
module slrl_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_req_valid,
    input logic                           i_req_ready,
    input logic                           i_res_valid,
    input logic                           i_res_ready,
    input logic                           i_res_allowed,
    input logic [slrl_pkg::CNT_OUT_W-1:0] i_res_in_window
);

    // A beat that is held back keeps its payload.
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> $stable(i_res_allowed) && $stable(i_res_in_window))
        else $error("result payload changed while stalled");

    a_res_valid_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result valid dropped while stalled");

    // An allowed request has just been recorded, so the window holds at least it.
    a_allowed_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_allowed |-> i_res_in_window != '0)
        else $error("allowed result with empty window");

    // The block works on one request at a time.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken while previous one is in flight");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid after reset");

endmodule

bind sliding_log_rate_limiter slrl_checker u_slrl_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_req_valid     (i_req.valid),
    .i_req_ready     (i_req.ready),
    .i_res_valid     (o_res.valid),
    .i_res_ready     (o_res.ready),
    .i_res_allowed   (o_res.allowed),
    .i_res_in_window (o_res.in_window)
);
